// ===== rtl/core/bus_telegram_parser_unit_assert.svh =====
// Assertion macros used by the checker file btp_checker.sv.
`ifndef BUS_TELEGRAM_PARSER_UNIT_ASSERT_SVH
`define BUS_TELEGRAM_PARSER_UNIT_ASSERT_SVH

// Check the consequent in the next cycle, ignored while reset is high.
`define BTP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("btp assertion failed");

// Check the consequent in the same cycle, ignored while reset is high.
`define BTP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("btp assertion failed");

// Check the consequent in the next cycle, also across reset.
`define BTP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("btp assertion failed");

`endif

// ===== rtl/core/btp_pkg.sv =====
`timescale 1ns / 1ps
package btp_pkg;

   // Default maximum data bytes taken in one data phase
   localparam int MAX_DATA_DEFAULT = 256;
   // Width used to compare the data counter with a length byte
   localparam int CNT_CMP_W = 9;

   localparam logic [7:0] SYNC_BYTE  = 8'hAA;
   localparam logic [7:0] BCAST_DEST = 8'hFE;
   localparam logic [7:0] BCAST_PRI  = 8'h07;
   localparam logic [7:0] BCAST_SEC  = 8'h00;
   localparam logic [7:0] ACK_BYTE   = 8'h00;
   localparam logic [7:0] ZERO_LEN   = 8'h00;
   localparam logic [7:0] CLEAR_BYTE = 8'hFF;

   // Byte roles
   localparam logic [3:0] ROLE_SYNC     = 4'd0;
   localparam logic [3:0] ROLE_SOURCE   = 4'd1;
   localparam logic [3:0] ROLE_DEST     = 4'd2;
   localparam logic [3:0] ROLE_CMD      = 4'd3;
   localparam logic [3:0] ROLE_SUBCMD   = 4'd4;
   localparam logic [3:0] ROLE_LEN      = 4'd5;
   localparam logic [3:0] ROLE_DATA     = 4'd6;
   localparam logic [3:0] ROLE_CRC      = 4'd7;
   localparam logic [3:0] ROLE_ACK      = 4'd8;
   localparam logic [3:0] ROLE_ANS_LEN  = 4'd9;
   localparam logic [3:0] ROLE_ANS_DATA = 4'd10;
   localparam logic [3:0] ROLE_ANS_CRC  = 4'd11;
   localparam logic [3:0] ROLE_ANS_ACK  = 4'd12;

   // Telegram events
   localparam logic [2:0] EV_NONE        = 3'd0;
   localparam logic [2:0] EV_BCAST_DONE  = 3'd1;
   localparam logic [2:0] EV_DONE_NO_ANS = 3'd2;
   localparam logic [2:0] EV_MASTER_NACK = 3'd3;
   localparam logic [2:0] EV_DONE_ANS    = 3'd4;
   localparam logic [2:0] EV_ANSWER_NACK = 3'd5;
   localparam logic [2:0] EV_SYNC_LOST   = 3'd6;

   // Parse phases, one-hot
   typedef enum logic [11:0] {
      PH_SOURCE   = 12'b0000_0000_0001,
      PH_DEST     = 12'b0000_0000_0010,
      PH_CMD      = 12'b0000_0000_0100,
      PH_SUBCMD   = 12'b0000_0000_1000,
      PH_LEN      = 12'b0000_0001_0000,
      PH_DATA     = 12'b0000_0010_0000,
      PH_CRC      = 12'b0000_0100_0000,
      PH_ACK      = 12'b0000_1000_0000,
      PH_ANS_LEN  = 12'b0001_0000_0000,
      PH_ANS_DATA = 12'b0010_0000_0000,
      PH_ANS_CRC  = 12'b0100_0000_0000,
      PH_ANS_ACK  = 12'b1000_0000_0000
   } phase_type;

   // One result item
   typedef struct packed {
      logic [3:0] byte_role;
      logic [7:0] data_index;
      logic [7:0] data_byte;
      logic [2:0] event_res;
      logic [7:0] source_addr;
      logic [7:0] dest_addr;
      logic [7:0] primary_cmd;
      logic [7:0] secondary_cmd;
      logic [7:0] master_length;
      logic [7:0] answer_length;
      logic [7:0] master_check;
      logic [7:0] answer_check;
   } result_type;

endpackage

// ===== rtl/core/btp_parser.sv =====
`timescale 1ns / 1ps
module btp_parser
   import btp_pkg::*;
#(
   parameter int MAX_DATA = MAX_DATA_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] rx_byte,
   output result_type result
);

   localparam int CNT_W = $clog2(MAX_DATA + 1);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_inc;
   logic [7:0]       src_ff, src_in;
   logic [7:0]       dest_ff, dest_in;
   logic [7:0]       pri_ff, pri_in;
   logic [7:0]       sec_ff, sec_in;
   logic [7:0]       mlen_ff, mlen_in;
   logic [7:0]       alen_ff, alen_in;
   logic [7:0]       mcrc_ff, mcrc_in;
   logic [7:0]       acrc_ff, acrc_in;
   logic [7:0]       cur_len;
   logic             data_end;
   logic             bcast;
   logic [3:0]       role;
   logic [7:0]       idx;
   logic [2:0]       ev;

   // Data phase bookkeeping
   assign cnt_inc  = cnt_ff + 1'b1;
   assign cur_len  = (phase_ff == PH_DATA) ? mlen_ff : alen_ff;
   assign data_end = (CNT_CMP_W'(cnt_inc) == CNT_CMP_W'(cur_len)) ||
                     (CNT_CMP_W'(cnt_inc) >= CNT_CMP_W'(MAX_DATA));
   assign bcast    = (dest_ff == BCAST_DEST) ||
                     ((pri_ff == BCAST_PRI) && (sec_ff == BCAST_SEC));

   // Walk the telegram one byte at a time
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      src_in   = src_ff;
      dest_in  = dest_ff;
      pri_in   = pri_ff;
      sec_in   = sec_ff;
      mlen_in  = mlen_ff;
      alen_in  = alen_ff;
      mcrc_in  = mcrc_ff;
      acrc_in  = acrc_ff;
      role     = ROLE_SYNC;
      idx      = 8'd0;
      ev       = EV_NONE;
      unique case (phase_ff)
         PH_SOURCE: begin
            if (rx_byte != SYNC_BYTE) begin
               src_in   = rx_byte;
               dest_in  = CLEAR_BYTE;
               pri_in   = CLEAR_BYTE;
               sec_in   = CLEAR_BYTE;
               mlen_in  = CLEAR_BYTE;
               alen_in  = CLEAR_BYTE;
               mcrc_in  = CLEAR_BYTE;
               acrc_in  = CLEAR_BYTE;
               role     = ROLE_SOURCE;
               phase_in = PH_DEST;
            end
         end
         PH_DEST: begin
            dest_in  = rx_byte;
            role     = ROLE_DEST;
            phase_in = PH_CMD;
         end
         PH_CMD: begin
            pri_in   = rx_byte;
            role     = ROLE_CMD;
            phase_in = PH_SUBCMD;
         end
         PH_SUBCMD: begin
            sec_in   = rx_byte;
            role     = ROLE_SUBCMD;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            mlen_in  = rx_byte;
            role     = ROLE_LEN;
            cnt_in   = '0;
            phase_in = (rx_byte != ZERO_LEN) ? PH_DATA : PH_CRC;
         end
         PH_DATA, PH_ANS_DATA: begin
            if (rx_byte == SYNC_BYTE) begin
               ev       = EV_SYNC_LOST;
               phase_in = PH_SOURCE;
            end else begin
               role   = (phase_ff == PH_DATA) ? ROLE_DATA : ROLE_ANS_DATA;
               idx    = 8'(cnt_ff);
               cnt_in = cnt_inc;
               if (data_end) begin
                  phase_in = (phase_ff == PH_DATA) ? PH_CRC : PH_ANS_CRC;
               end
            end
         end
         PH_CRC: begin
            mcrc_in = rx_byte;
            role    = ROLE_CRC;
            if (bcast) begin
               ev       = EV_BCAST_DONE;
               phase_in = PH_SOURCE;
            end else begin
               phase_in = PH_ACK;
            end
         end
         PH_ACK: begin
            if (rx_byte == ACK_BYTE) begin
               role     = ROLE_ACK;
               phase_in = PH_ANS_LEN;
            end else if (rx_byte == SYNC_BYTE) begin
               ev       = EV_DONE_NO_ANS;
               phase_in = PH_SOURCE;
            end else begin
               role     = ROLE_ACK;
               ev       = EV_MASTER_NACK;
               phase_in = PH_SOURCE;
            end
         end
         PH_ANS_LEN: begin
            if (rx_byte == SYNC_BYTE) begin
               ev       = EV_DONE_NO_ANS;
               phase_in = PH_SOURCE;
            end else begin
               alen_in  = rx_byte;
               role     = ROLE_ANS_LEN;
               cnt_in   = '0;
               phase_in = (rx_byte != ZERO_LEN) ? PH_ANS_DATA : PH_ANS_CRC;
            end
         end
         PH_ANS_CRC: begin
            acrc_in  = rx_byte;
            role     = ROLE_ANS_CRC;
            phase_in = PH_ANS_ACK;
         end
         PH_ANS_ACK: begin
            role     = ROLE_ANS_ACK;
            ev       = (rx_byte == ACK_BYTE) ? EV_DONE_ANS : EV_ANSWER_NACK;
            phase_in = PH_SOURCE;
         end
         default: begin
            phase_in = PH_SOURCE;
         end
      endcase
   end

   // Result reflects the held fields after this byte
   always_comb begin
      result.byte_role     = role;
      result.data_index    = idx;
      result.data_byte     = rx_byte;
      result.event_res     = ev;
      result.source_addr   = src_in;
      result.dest_addr     = dest_in;
      result.primary_cmd   = pri_in;
      result.secondary_cmd = sec_in;
      result.master_length = mlen_in;
      result.answer_length = alen_in;
      result.master_check  = mcrc_in;
      result.answer_check  = acrc_in;
   end

   // Advance the parse state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SOURCE;
         cnt_ff   <= '0;
         src_ff   <= 8'h00;
         dest_ff  <= CLEAR_BYTE;
         pri_ff   <= CLEAR_BYTE;
         sec_ff   <= CLEAR_BYTE;
         mlen_ff  <= CLEAR_BYTE;
         alen_ff  <= CLEAR_BYTE;
         mcrc_ff  <= CLEAR_BYTE;
         acrc_ff  <= CLEAR_BYTE;
      end else if (take) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         src_ff   <= src_in;
         dest_ff  <= dest_in;
         pri_ff   <= pri_in;
         sec_ff   <= sec_in;
         mlen_ff  <= mlen_in;
         alen_ff  <= alen_in;
         mcrc_ff  <= mcrc_in;
         acrc_ff  <= acrc_in;
      end
   end

endmodule

// ===== rtl/core/bus_telegram_parser_unit.sv =====
`timescale 1ns / 1ps
// A request's response is valid in the cycle after the request is accepted.
// One request per cycle while responses are taken; the parse state updates in the
// accepting cycle and the response register is refilled as it drains.
// Reset (synchronous, active high) returns to waiting for a source byte, clears
// the source to 0, the other header fields to 0xFF, and empties the response register.
module bus_telegram_parser_unit
   import btp_pkg::*;
#(
   parameter int MAX_DATA = MAX_DATA_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_byte_role,
   output logic [7:0] rsp_data_index,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_source_addr,
   output logic [7:0] rsp_dest_addr,
   output logic [7:0] rsp_primary_cmd,
   output logic [7:0] rsp_secondary_cmd,
   output logic [7:0] rsp_master_length,
   output logic [7:0] rsp_answer_length,
   output logic [7:0] rsp_master_check,
   output logic [7:0] rsp_answer_check
);

   logic       take;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;

   // Accept when the response register is empty or drains this cycle
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign take      = req_valid && req_ready;

   btp_parser #(
      .MAX_DATA (MAX_DATA)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_role     = rsp_ff.byte_role;
   assign rsp_data_index    = rsp_ff.data_index;
   assign rsp_data_byte     = rsp_ff.data_byte;
   assign rsp_event_res     = rsp_ff.event_res;
   assign rsp_source_addr   = rsp_ff.source_addr;
   assign rsp_dest_addr     = rsp_ff.dest_addr;
   assign rsp_primary_cmd   = rsp_ff.primary_cmd;
   assign rsp_secondary_cmd = rsp_ff.secondary_cmd;
   assign rsp_master_length = rsp_ff.master_length;
   assign rsp_answer_length = rsp_ff.answer_length;
   assign rsp_master_check  = rsp_ff.master_check;
   assign rsp_answer_check  = rsp_ff.answer_check;

endmodule

// ===== rtl/core/btp_checker.sv =====
`timescale 1ns / 1ps
`include "bus_telegram_parser_unit_assert.svh"
module btp_checker
   import btp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_byte_role,
   input logic [7:0] rsp_data_byte,
   input logic [2:0] rsp_event_res,
   input logic [7:0] rsp_dest_addr
);

   // Reset drops any pending response
   `BTP_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

   // Every accepted request yields a response in the next cycle
   `BTP_ASSERT_NEXT(a_req_to_rsp, req_valid && req_ready, rsp_valid)

   // A new source byte starts a telegram with a cleared destination
   `BTP_ASSERT_SAME(a_source_clears, rsp_valid && (rsp_byte_role == ROLE_SOURCE),
                    rsp_dest_addr == CLEAR_BYTE && rsp_event_res == EV_NONE)

   // A sync byte never passes as data
   `BTP_ASSERT_SAME(a_data_not_sync,
                    rsp_valid && (rsp_byte_role == ROLE_DATA ||
                                  rsp_byte_role == ROLE_ANS_DATA),
                    rsp_data_byte != SYNC_BYTE)

   // A stalled response holds
   `BTP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_data_byte))

endmodule

bind bus_telegram_parser_unit btp_checker u_btp_checker (.*);
